// ===== hdl/kevt_pkg.sv =====
`default_nettype none
package kevt_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned MOD_CTRL_BIT = 0;
  localparam int unsigned MOD_ALT_BIT  = 1;

  localparam logic [7:0] VK_BACK        = 8'h08;
  localparam logic [7:0] VK_TAB         = 8'h09;
  localparam logic [7:0] VK_ENTER       = 8'h0D;
  localparam logic [7:0] VK_ESC         = 8'h1B;
  localparam logic [7:0] VK_PAGE_UP     = 8'h21;
  localparam logic [7:0] VK_NEXT        = 8'h22;
  localparam logic [7:0] VK_END         = 8'h23;
  localparam logic [7:0] VK_HOME        = 8'h24;
  localparam logic [7:0] VK_LEFT        = 8'h25;
  localparam logic [7:0] VK_UP          = 8'h26;
  localparam logic [7:0] VK_ARROW_RIGHT = 8'h27;
  localparam logic [7:0] VK_DOWN        = 8'h28;
  localparam logic [7:0] VK_INS         = 8'h2D;
  localparam logic [7:0] VK_DEL         = 8'h2E;
  localparam logic [7:0] VK_KEY_C       = 8'h43;
  localparam logic [7:0] VK_KEY_D       = 8'h44;
  localparam logic [7:0] VK_F1          = 8'h70;
  localparam logic [7:0] VK_F2          = 8'h71;
  localparam logic [7:0] VK_F3          = 8'h72;
  localparam logic [7:0] VK_F4          = 8'h73;

  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_EOT    = 8'h04;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_5      = 8'h35;
  localparam logic [7:0] CH_6      = 8'h36;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  localparam logic [15:0] SURR_LO  = 16'hD800;
  localparam logic [15:0] SURR_HI  = 16'hDFFF;
  localparam logic [15:0] REPL_CH  = 16'hFFFD;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } seq_t;

  typedef struct packed {
    logic emit;
    seq_t seq;
  } cls_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic cls_t classify(logic down, logic [1:0] mods, logic [7:0] vk,
                                    logic [15:0] cu);
    cls_t            r;
    logic [15:0]     u;
    logic [2:0][7:0] ub;
    logic [1:0]      ul;
    r.emit         = 1'b0;
    r.seq.bytes    = '0;
    r.seq.last_idx = 2'd0;
    ub             = '0;
    u              = ((cu >= SURR_LO) && (cu <= SURR_HI)) ? REPL_CH : cu;
    if (cu < 16'h0080) begin
      ub[0] = cu[7:0];
      ul    = 2'd0;
    end else if (cu < 16'h0800) begin
      ub[0] = {3'b110, cu[10:6]};
      ub[1] = {2'b10, cu[5:0]};
      ul    = 2'd1;
    end else begin
      ub[0] = {4'b1110, u[15:12]};
      ub[1] = {2'b10, u[11:6]};
      ub[2] = {2'b10, u[5:0]};
      ul    = 2'd2;
    end
    if (down) begin
      r.emit         = 1'b1;
      r.seq.bytes[0] = CH_ESC;
      r.seq.bytes[1] = CH_LBRACK;
      if (mods[MOD_CTRL_BIT] && (vk == VK_KEY_C)) begin
        r.seq.bytes[0] = CH_ETX;
      end else if (mods[MOD_CTRL_BIT] && (vk == VK_KEY_D)) begin
        r.seq.bytes[0] = CH_EOT;
      end else begin
        case (vk)
          VK_UP: begin
            r.seq.bytes[2] = CH_A;
            r.seq.last_idx = 2'd2;
          end
          VK_DOWN: begin
            r.seq.bytes[2] = CH_B;
            r.seq.last_idx = 2'd2;
          end
          VK_ARROW_RIGHT: begin
            r.seq.bytes[2] = CH_C;
            r.seq.last_idx = 2'd2;
          end
          VK_LEFT: begin
            r.seq.bytes[2] = CH_D;
            r.seq.last_idx = 2'd2;
          end
          VK_HOME: begin
            r.seq.bytes[2] = CH_H;
            r.seq.last_idx = 2'd2;
          end
          VK_END: begin
            r.seq.bytes[2] = CH_F;
            r.seq.last_idx = 2'd2;
          end
          VK_PAGE_UP: begin
            r.seq.bytes[2] = CH_5;
            r.seq.bytes[3] = CH_TILDE;
            r.seq.last_idx = 2'd3;
          end
          VK_NEXT: begin
            r.seq.bytes[2] = CH_6;
            r.seq.bytes[3] = CH_TILDE;
            r.seq.last_idx = 2'd3;
          end
          VK_DEL: begin
            r.seq.bytes[2] = CH_3;
            r.seq.bytes[3] = CH_TILDE;
            r.seq.last_idx = 2'd3;
          end
          VK_INS: begin
            r.seq.bytes[2] = CH_2;
            r.seq.bytes[3] = CH_TILDE;
            r.seq.last_idx = 2'd3;
          end
          VK_F1, VK_F2, VK_F3, VK_F4: begin
            r.seq.bytes[1] = CH_O;
            r.seq.bytes[2] = CH_P + {6'd0, vk[1:0]};
            r.seq.last_idx = 2'd2;
          end
          VK_ENTER: r.seq.bytes[0] = CH_CR;
          VK_TAB:   r.seq.bytes[0] = CH_TAB;
          VK_BACK:  r.seq.bytes[0] = CH_DEL;
          VK_ESC:   r.seq.bytes[0] = CH_ESC;
          default: begin
            if (cu == 16'h0000) begin
              r.emit = 1'b0;
            end else if (mods[MOD_ALT_BIT]) begin
              r.seq.bytes[0] = CH_ESC;
              r.seq.bytes[1] = ub[0];
              r.seq.bytes[2] = ub[1];
              r.seq.bytes[3] = ub[2];
              r.seq.last_idx = ul + 2'd1;
            end else begin
              r.seq.bytes[0] = ub[0];
              r.seq.bytes[1] = ub[1];
              r.seq.bytes[2] = ub[2];
              r.seq.bytes[3] = 8'h00;
              r.seq.last_idx = ul;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/kevt_if.sv =====
`default_nettype none
interface kevt_key_if;
  logic        valid;
  logic        ready;
  logic        key_down;
  logic [1:0]  modifier_bits;
  logic [7:0]  virtual_key;
  logic [15:0] char_unit;

  modport source (output valid, key_down, modifier_bits, virtual_key, char_unit,
                  input ready);
  modport sink (input valid, key_down, modifier_bits, virtual_key, char_unit,
                output ready);
endinterface

interface kevt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/kevt_front.sv =====
`default_nettype none
module kevt_front (
  kevt_key_if.sink        key_i,
  input  kevt_pkg::qstat_t stat_i,
  output logic             push_o,
  output kevt_pkg::seq_t   data_o
);

  kevt_pkg::cls_t cls;

  always_comb begin
    cls         = kevt_pkg::classify(key_i.key_down, key_i.modifier_bits,
                                     key_i.virtual_key, key_i.char_unit);
    key_i.ready = !stat_i.full;
    // drop transactions that yield no bytes
    push_o      = key_i.valid && key_i.ready && cls.emit;
    data_o      = cls.seq;
  end

endmodule
`default_nettype wire

// ===== hdl/kevt_queue.sv =====
`default_nettype none
module kevt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kevt_pkg::seq_t   data_i,
  input  logic             pop_i,
  output kevt_pkg::seq_t   data_o,
  output kevt_pkg::qstat_t stat_o
);

  localparam logic [kevt_pkg::QPTR_W-1:0] PTR_LAST = kevt_pkg::QPTR_W'(kevt_pkg::QDEPTH - 1);
  localparam logic [kevt_pkg::QCNT_W-1:0] CNT_FULL = kevt_pkg::QCNT_W'(kevt_pkg::QDEPTH);

  kevt_pkg::seq_t                mem_q [kevt_pkg::QDEPTH];
  logic [kevt_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [kevt_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [kevt_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  always_comb begin
    stat_o.full  = (cnt_q == CNT_FULL);
    stat_o.empty = (cnt_q == '0);
    stat_o.count = cnt_q;
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    data_o       = mem_q[rd_ptr_q];
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    cnt_d        = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/kevt_back.sv =====
`default_nettype none
module kevt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kevt_pkg::seq_t   data_i,
  input  kevt_pkg::qstat_t stat_i,
  output logic             pop_o,
  kevt_byte_if.source      bytes_o
);

  kevt_pkg::seq_t cur_q, cur_d;
  logic [1:0]     idx_q, idx_d;
  logic           vld_q, vld_d;
  logic           take, done;

  always_comb begin
    bytes_o.valid     = vld_q;
    bytes_o.out_byte  = cur_q.bytes[idx_q];
    bytes_o.last_byte = (idx_q == cur_q.last_idx);
    take              = vld_q && bytes_o.ready;
    done              = take && bytes_o.last_byte;
    pop_o             = !stat_i.empty && (!vld_q || done);
    cur_d             = cur_q;
    idx_d             = idx_q;
    vld_d             = vld_q;
    if (pop_o) begin
      cur_d = data_i;
      idx_d = 2'd0;
      vld_d = 1'b1;
    end else if (done) begin
      vld_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule
`default_nettype wire

// ===== hdl/key_event_to_vt_bytes_top.sv =====
// Key event to VT byte encoder.
// key_i takes one key event per transaction (key_down, modifier_bits,
// virtual_key, char_unit); bytes_o gives the terminal byte stream, one byte
// per transaction, with last_byte set on the final byte of each event.
// Releases and non-special keys with a zero char_unit give no bytes and are absorbed.
// The front classifies an event in the cycle it is accepted and writes its
// byte sequence into a two-entry queue; once the queue holds it, the back
// pops the sequence into its own register and presents its first byte, so
// the queue entry and the back register lie between acceptance and the
// first byte. The back sends one byte per cycle while bytes_o.ready is high,
// and an event gives 1 to 4 bytes; sustained rate is set by that byte loop.
// Events keep being accepted while the queue has room, also while bytes_o
// is stalled; a stalled receiver holds the current byte and fills the queue,
// after which key_i.ready drops. Reset empties the queue and the back.
`default_nettype none
module key_event_to_vt_bytes_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  kevt_key_if.sink    key_i,
  kevt_byte_if.source bytes_o
);

  kevt_pkg::qstat_t stat;
  kevt_pkg::seq_t   push_data, pop_data;
  logic             push, pop;

  kevt_front u_front (
    .key_i  (key_i),
    .stat_i (stat),
    .push_o (push),
    .data_o (push_data)
  );

  kevt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (stat)
  );

  kevt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (pop_data),
    .stat_i  (stat),
    .pop_o   (pop),
    .bytes_o (bytes_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("push into full queue");

  a_release_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready && !key_i.key_down) |-> !push)
    else $error("key release produced bytes");

  a_seq_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_o.valid && bytes_o.ready && !bytes_o.last_byte) |=> bytes_o.valid)
    else $error("byte sequence broken before last byte");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= kevt_pkg::QCNT_W'(kevt_pkg::QDEPTH))
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== tb/sv/tb_key_event_to_vt_bytes_top.sv =====
`timescale 1ns / 100ps
module tb_key_event_to_vt_bytes_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PRESSES_PER_PHASE = 53;
  localparam int MAX_PRINTED    = 50;

  localparam logic [1:0] MODS_NONE = 2'b00;
  localparam logic [1:0] MODS_CTRL = 2'b01 << kevt_pkg::MOD_CTRL_BIT;
  localparam logic [1:0] MODS_ALT  = 2'b01 << kevt_pkg::MOD_ALT_BIT;
  localparam logic [1:0] MODS_BOTH = MODS_CTRL | MODS_ALT;

  localparam logic [7:0] SPECIAL_KEYS [18] = '{
    kevt_pkg::VK_UP, kevt_pkg::VK_DOWN, kevt_pkg::VK_ARROW_RIGHT, kevt_pkg::VK_LEFT,
    kevt_pkg::VK_HOME, kevt_pkg::VK_END, kevt_pkg::VK_PAGE_UP, kevt_pkg::VK_NEXT,
    kevt_pkg::VK_DEL, kevt_pkg::VK_INS, kevt_pkg::VK_F1, kevt_pkg::VK_F2,
    kevt_pkg::VK_F3, kevt_pkg::VK_F4, kevt_pkg::VK_ENTER, kevt_pkg::VK_TAB,
    kevt_pkg::VK_BACK, kevt_pkg::VK_ESC
  };

  typedef struct packed {
    logic        key_down;
    logic [1:0]  modifier_bits;
    logic [7:0]  virtual_key;
    logic [15:0] char_unit;
  } key_event_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } vt_byte_t;

  logic clk_i;
  logic rst_ni;

  kevt_key_if  key_bus ();
  kevt_byte_if byte_bus ();

  key_event_to_vt_bytes_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (key_bus.sink),
    .bytes_o (byte_bus.source)
  );

  vt_byte_t expected_bytes [$];
  int       mismatch_count = 0;
  int       presses_sent   = 0;
  int       releases_sent  = 0;
  int       bytes_checked  = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void predict_vt_bytes(input key_event_t ev);
    logic [7:0]  seq [4];
    logic [15:0] cp;
    int          n;
    vt_byte_t    b;
    n = 0;
    seq[0] = kevt_pkg::CH_ESC;
    seq[1] = kevt_pkg::CH_LBRACK;
    seq[2] = 8'h00;
    seq[3] = 8'h00;
    if (!ev.key_down) begin
      return;
    end
    if (ev.modifier_bits[kevt_pkg::MOD_CTRL_BIT] && ev.virtual_key == kevt_pkg::VK_KEY_C) begin
      seq[0] = kevt_pkg::CH_ETX;
      n = 1;
    end else if (ev.modifier_bits[kevt_pkg::MOD_CTRL_BIT] &&
                 ev.virtual_key == kevt_pkg::VK_KEY_D) begin
      seq[0] = kevt_pkg::CH_EOT;
      n = 1;
    end else begin
      case (ev.virtual_key)
        kevt_pkg::VK_UP: begin
          seq[2] = kevt_pkg::CH_A;
          n = 3;
        end
        kevt_pkg::VK_DOWN: begin
          seq[2] = kevt_pkg::CH_B;
          n = 3;
        end
        kevt_pkg::VK_ARROW_RIGHT: begin
          seq[2] = kevt_pkg::CH_C;
          n = 3;
        end
        kevt_pkg::VK_LEFT: begin
          seq[2] = kevt_pkg::CH_D;
          n = 3;
        end
        kevt_pkg::VK_HOME: begin
          seq[2] = kevt_pkg::CH_H;
          n = 3;
        end
        kevt_pkg::VK_END: begin
          seq[2] = kevt_pkg::CH_F;
          n = 3;
        end
        kevt_pkg::VK_PAGE_UP: begin
          seq[2] = kevt_pkg::CH_5;
          seq[3] = kevt_pkg::CH_TILDE;
          n = 4;
        end
        kevt_pkg::VK_NEXT: begin
          seq[2] = kevt_pkg::CH_6;
          seq[3] = kevt_pkg::CH_TILDE;
          n = 4;
        end
        kevt_pkg::VK_DEL: begin
          seq[2] = kevt_pkg::CH_3;
          seq[3] = kevt_pkg::CH_TILDE;
          n = 4;
        end
        kevt_pkg::VK_INS: begin
          seq[2] = kevt_pkg::CH_2;
          seq[3] = kevt_pkg::CH_TILDE;
          n = 4;
        end
        kevt_pkg::VK_F1, kevt_pkg::VK_F2, kevt_pkg::VK_F3, kevt_pkg::VK_F4: begin
          seq[1] = kevt_pkg::CH_O;
          seq[2] = kevt_pkg::CH_P + (ev.virtual_key - kevt_pkg::VK_F1);
          n = 3;
        end
        kevt_pkg::VK_ENTER: begin
          seq[0] = kevt_pkg::CH_CR;
          n = 1;
        end
        kevt_pkg::VK_TAB: begin
          seq[0] = kevt_pkg::CH_TAB;
          n = 1;
        end
        kevt_pkg::VK_BACK: begin
          seq[0] = kevt_pkg::CH_DEL;
          n = 1;
        end
        kevt_pkg::VK_ESC: begin
          seq[0] = kevt_pkg::CH_ESC;
          n = 1;
        end
        default: begin
          cp = ev.char_unit;
          if (cp != 16'h0000) begin
            if (ev.modifier_bits[kevt_pkg::MOD_ALT_BIT]) begin
              seq[n] = kevt_pkg::CH_ESC;
              n++;
            end
            if (cp < 16'h0080) begin
              seq[n] = cp[7:0];
              n++;
            end else if (cp < 16'h0800) begin
              seq[n]     = {3'b110, cp[10:6]};
              seq[n + 1] = {2'b10, cp[5:0]};
              n += 2;
            end else begin
              if (cp >= kevt_pkg::SURR_LO && cp <= kevt_pkg::SURR_HI) begin
                cp = kevt_pkg::REPL_CH;
              end
              seq[n]     = {4'b1110, cp[15:12]};
              seq[n + 1] = {2'b10, cp[11:6]};
              seq[n + 2] = {2'b10, cp[5:0]};
              n += 3;
            end
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      b.out_byte  = seq[i];
      b.last_byte = (i == n - 1);
      expected_bytes.insert(expected_bytes.size(), b);
    end
  endfunction

  function automatic logic [15:0] pick_char_unit();
    logic [15:0] cu;
    case ($urandom_range(0, 5))
      0:       cu = 16'($urandom_range(1, 16'h007F));
      1:       cu = 16'($urandom_range(16'h0080, 16'h07FF));
      2:       cu = 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       cu = 16'($urandom_range(kevt_pkg::SURR_LO, kevt_pkg::SURR_HI));
      4:       cu = 16'h0000;
      default: cu = 16'($urandom());
    endcase
    return cu;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic send_key_event(input key_event_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      key_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    key_bus.valid         <= 1'b1;
    key_bus.key_down      <= ev.key_down;
    key_bus.modifier_bits <= ev.modifier_bits;
    key_bus.virtual_key   <= ev.virtual_key;
    key_bus.char_unit     <= ev.char_unit;
    do @(posedge clk_i); while (!key_bus.ready);
    predict_vt_bytes(ev);
    if (ev.key_down) begin
      presses_sent++;
    end else begin
      releases_sent++;
    end
  endtask

  task automatic drain_bytes();
    key_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
  endtask

  task automatic test_releases_and_control();
    send_key_event(key_event_t'{1'b0, MODS_BOTH, kevt_pkg::VK_KEY_C, 16'hFFFF});
    send_key_event(key_event_t'{1'b1, MODS_BOTH, kevt_pkg::VK_KEY_C, 16'h0003});
    send_key_event(key_event_t'{1'b1, MODS_CTRL, kevt_pkg::VK_KEY_D, 16'h0000});
    drain_bytes();
  endtask

  task automatic test_special_keys();
    for (int i = 0; i < 18; i++) begin
      send_key_event(key_event_t'{1'b1, 2'(i), SPECIAL_KEYS[i], 16'(i * 16'h0F0F)});
    end
    drain_bytes();
  endtask

  task automatic test_character_encoding();
    send_key_event(key_event_t'{1'b1, MODS_ALT,  8'h41, 16'h0000});
    send_key_event(key_event_t'{1'b1, MODS_ALT,  8'h41, 16'h007F});
    send_key_event(key_event_t'{1'b1, MODS_NONE, 8'h00, 16'h0080});
    send_key_event(key_event_t'{1'b1, MODS_ALT,  8'h55, 16'h07FF});
    send_key_event(key_event_t'{1'b1, MODS_NONE, 8'h56, kevt_pkg::SURR_LO});
    send_key_event(key_event_t'{1'b1, MODS_BOTH, 8'h57, kevt_pkg::SURR_HI});
    send_key_event(key_event_t'{1'b1, MODS_ALT,  8'hFF, 16'hFFFF});
    drain_bytes();
  endtask

  task automatic test_random_events(input int idle_pct, input int stall_pct, input int presses);
    key_event_t ev;
    int         kind;
    int         done;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < presses) begin
      kind             = $urandom_range(0, 99);
      ev.key_down      = 1'b1;
      ev.modifier_bits = 2'($urandom_range(0, 3));
      ev.char_unit     = pick_char_unit();
      if (kind < 15) begin
        ev.key_down    = 1'b0;
        ev.virtual_key = 8'($urandom_range(0, 255));
      end else if (kind < 25) begin
        ev.virtual_key = $urandom_range(0, 1) ? kevt_pkg::VK_KEY_C : kevt_pkg::VK_KEY_D;
      end else if (kind < 55) begin
        ev.virtual_key = SPECIAL_KEYS[$urandom_range(0, 17)];
      end else begin
        ev.virtual_key = 8'($urandom_range(0, 255));
      end
      send_key_event(ev);
      if (ev.key_down) begin
        done++;
      end
    end
    drain_bytes();
  endtask

  always @(posedge clk_i) begin : byte_check
    vt_byte_t want;
    if (rst_ni && byte_bus.valid && byte_bus.ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte 0x%02h last=%0b",
                                  byte_bus.out_byte, byte_bus.last_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (byte_bus.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                    byte_bus.out_byte, want.out_byte));
        end
        if (byte_bus.last_byte !== want.last_byte) begin
          report_mismatch($sformatf("last_byte %0b on 0x%02h, expected %0b",
                                    byte_bus.last_byte, byte_bus.out_byte,
                                    want.last_byte));
        end
      end
    end
    byte_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((key_bus.valid && key_bus.ready) || (byte_bus.valid && byte_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no transaction for %0d cycles, %0d bytes outstanding",
             WATCHDOG_LIMIT, expected_bytes.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    key_bus.valid         = 1'b0;
    key_bus.key_down      = 1'b0;
    key_bus.modifier_bits = MODS_NONE;
    key_bus.virtual_key   = 8'h00;
    key_bus.char_unit     = 16'h0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_releases_and_control();
    test_special_keys();
    test_character_encoding();
    test_random_events(0, 0, PRESSES_PER_PHASE);
    test_random_events(82, 0, PRESSES_PER_PHASE);
    test_random_events(0, 82, PRESSES_PER_PHASE);
    test_random_events(9, 9, PRESSES_PER_PHASE);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d key presses and %0d releases; checked %0d terminal bytes",
             presses_sent, releases_sent, bytes_checked);
    $display("Flow control: free-running, sparse sender, stalled receiver, light jitter");
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
